/* hw/rtl/swcd_pkg.sv */
// Shared types, constants and functions for the sensor word CRC deframer.
package swcd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [8:0] IDX_MUL  = 9'd499;

    localparam logic [2:0] POS_W0_HI  = 3'd0;
    localparam logic [2:0] POS_W0_LO  = 3'd1;
    localparam logic [2:0] POS_W0_CRC = 3'd2;
    localparam logic [2:0] POS_W1_HI  = 3'd3;
    localparam logic [2:0] POS_W1_LO  = 3'd4;
    localparam logic [2:0] POS_W1_CRC = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] voc_raw;
        logic [15:0] nox_raw;
        logic [8:0]  voc_idx;
        logic [8:0]  nox_idx;
    } t_out_beat;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(raw * 499 / 65535) + 1; division by 65535 via x + (x >> 16) + 1, then >> 16
    function automatic logic [8:0] scale_index(input logic [15:0] raw);
        logic [24:0] p;
        logic [25:0] x;
        p = raw * IDX_MUL;
        x = {1'b0, p} + {17'd0, p[24:16]} + 26'd1;
        return 9'(x[25:16]) + 9'd1;
    endfunction

endpackage

/* hw/rtl/swcd_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
interface swcd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sensor_word_crc_deframer_top.sv */
// Top level of the sensor word CRC deframer.
// Takes one response byte per beat and accepts a new beat every cycle unless
// a sixth byte is waiting for the result register. A byte is registered on
// entry, then checked and folded into the running CRC in the next cycle; the
// sixth byte of a response loads the result register once that register is
// free, and the result is then offered from it. The result register
// holds a beat while the sink stalls; bytes that make no result keep flowing,
// and only a sixth byte waits for the result register to free up. The start
// flag forces the byte to position zero and restarts the CRC.
module sensor_word_crc_deframer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swcd_stream_if.sink         i_in,
    swcd_stream_if.source       o_out
);

    logic                  r_in_valid;
    swcd_pkg::t_in_beat    r_in_data;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_word0, n_word0;
    logic [15:0] r_word1, n_word1;
    logic        r_ok0, n_ok0;

    logic                  r_out_valid;
    swcd_pkg::t_out_beat   r_out_data, n_out_data;

    logic [2:0] s_pos;
    logic       s_emit;
    logic       s_adv;
    logic       s_ok;
    logic [7:0] s_b;

    always_comb begin
        s_b   = r_in_data.rx_byte;
        s_pos = r_in_data.frame_start ? swcd_pkg::POS_W0_HI : r_pos;
        if (s_pos > swcd_pkg::POS_W1_CRC) begin
            s_pos = swcd_pkg::POS_W0_HI;
        end
        s_emit = r_in_valid && (s_pos == swcd_pkg::POS_W1_CRC);
        s_adv  = r_in_valid && (!s_emit || !r_out_valid || o_out.ready);
        s_ok   = r_ok0 && (r_crc == s_b);
    end

    assign i_in.ready  = !r_in_valid || s_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_comb begin
        n_crc   = r_crc;
        n_hi    = r_hi;
        n_word0 = r_word0;
        n_word1 = r_word1;
        n_ok0   = r_ok0;
        n_pos   = (s_pos == swcd_pkg::POS_W1_CRC) ? swcd_pkg::POS_W0_HI : s_pos + 3'd1;
        unique case (s_pos)
            swcd_pkg::POS_W0_HI, swcd_pkg::POS_W1_HI: begin
                n_hi  = s_b;
                n_crc = swcd_pkg::crc_byte(swcd_pkg::CRC_INIT, s_b);
            end
            swcd_pkg::POS_W0_LO: begin
                n_word0 = {r_hi, s_b};
                n_crc   = swcd_pkg::crc_byte(r_crc, s_b);
            end
            swcd_pkg::POS_W1_LO: begin
                n_word1 = {r_hi, s_b};
                n_crc   = swcd_pkg::crc_byte(r_crc, s_b);
            end
            swcd_pkg::POS_W0_CRC: begin
                n_ok0 = (r_crc == s_b);
                n_crc = swcd_pkg::CRC_INIT;
            end
            default: begin
                n_crc = swcd_pkg::CRC_INIT;
            end
        endcase

        n_out_data.valid_res = s_ok;
        n_out_data.voc_raw   = s_ok ? r_word0 : 16'd0;
        n_out_data.nox_raw   = s_ok ? r_word1 : 16'd0;
        n_out_data.voc_idx   = s_ok ? swcd_pkg::scale_index(r_word0) : 9'd0;
        n_out_data.nox_idx   = s_ok ? swcd_pkg::scale_index(r_word1) : 9'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= swcd_pkg::POS_W0_HI;
            r_crc       <= swcd_pkg::CRC_INIT;
            r_hi        <= 8'd0;
            r_word0     <= 16'd0;
            r_word1     <= 16'd0;
            r_ok0       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (s_adv) begin
                r_pos   <= n_pos;
                r_crc   <= n_crc;
                r_hi    <= n_hi;
                r_word0 <= n_word0;
                r_word1 <= n_word1;
                r_ok0   <= n_ok0;
            end
            if (s_adv && s_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data;
        end
        if (s_adv && s_emit) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
